@@ src/mbt_pkg.sv @@
package mbt_pkg;

    localparam int NEURONS = 20;
    localparam int IDX_W   = (NEURONS > 1) ? $clog2(NEURONS) : 1;
    localparam int PROD_W  = 67;
    localparam logic signed [31:0] Q_ONE = 32'sd65536;

    typedef enum logic [2:0] {
        FUNC_TRAIN   = 3'd0,
        FUNC_INFER   = 3'd1,
        FUNC_LOAD_HW = 3'd2,
        FUNC_LOAD_OW = 3'd3,
        FUNC_READ    = 3'd4
    } func_t;

    typedef enum logic [2:0] {
        REG_IN_MIN    = 3'd0,
        REG_IN_RECIP  = 3'd1,
        REG_TGT_MIN   = 3'd2,
        REG_TGT_SPAN  = 3'd3,
        REG_TGT_RECIP = 3'd4,
        REG_MOMENTUM  = 3'd5,
        REG_OUT_RATE  = 3'd6,
        REG_HID_RATE  = 3'd7
    } reg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_NX0, ST_NX1, ST_F1, ST_F2, ST_F3, ST_FY,
        ST_IM, ST_IP, ST_TM, ST_TE, ST_OM, ST_OE,
        ST_B1, ST_B2, ST_B3, ST_B4, ST_B5, ST_B6, ST_B7, ST_B8, ST_B9,
        ST_RD
    } state_t;

    function automatic logic signed [31:0] sat_q(input logic signed [PROD_W-1:0] v);
        logic signed [31:0] r;
        if (v > PROD_W'(64'sh7FFFFFFF))
            r = 32'sh7FFFFFFF;
        else if (v < -PROD_W'(64'sh80000000))
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // round to nearest q16.16, ties up, then saturate
    function automatic logic signed [31:0] rnd_sat(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] q;
        q = (p + PROD_W'(32768)) >>> 16;
        return sat_q(q);
    endfunction

    // piecewise-linear sigmoid on |h|
    function automatic logic [16:0] sigm(input logic signed [31:0] h);
        logic [32:0] a;
        logic [32:0] y;
        logic [16:0] r;
        a = h[31] ? 33'(-{h[31], h}) : {1'b0, h};
        if (a >= 33'd327680)
            y = 33'd65536;
        else if (a >= 33'd155648)
            y = (a >> 5) + 33'd55296;
        else if (a >= 33'd65536)
            y = (a >> 3) + 33'd40960;
        else
            y = (a >> 2) + 33'd32768;
        r = h[31] ? 17'(33'd65536 - y) : y[16:0];
        return r;
    endfunction

endpackage

@@ src/mlp_backprop_momentum_trainer.sv @@
// one-input, one-output mlp with sigmoid hidden layer, trained online with momentum
// requests: func/sample/target/neuron_index/weight_value are taken at a clock edge
// with start high and busy low; busy stays high until the result is out
// results: done pulses for one cycle with prediction, error, hidden_weight and
// output_weight; the receiver cannot stall, the result is simply presented
// configuration: cfg_valid/cfg_ready write channel, cfg_ready is always high;
// cfg_index selects the register, cfg_data carries its value (low bits kept)
// sequencing: load and unused codes finish from idle, a read uses one read state,
// infer normalizes the input, runs a forward pass over all NEURONS units and
// rescales the output, train adds a backward pass per unit; one request at a time
// all products go through one shared 34x33 multiplier with a registered product,
// rounding and saturation happen in the following sequencer step
// reset clears weights, momentum deltas and registers to their defaults
module mlp_backprop_momentum_trainer
    import mbt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         func,
    input  logic signed [31:0] sample,
    input  logic signed [31:0] target,
    input  logic [5:0]         neuron_index,
    input  logic signed [31:0] weight_value,
    output logic               done,
    output logic signed [31:0] prediction,
    output logic signed [31:0] error,
    output logic signed [31:0] hidden_weight,
    output logic signed [31:0] output_weight,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    state_t state_reg, state_next;

    logic signed [31:0] in_min_reg, tgt_min_reg;
    logic [16:0]        in_recip_reg, tgt_recip_reg, mom_reg, orate_reg, hrate_reg;
    logic [30:0]        tgt_span_reg;

    logic signed [31:0] hw_reg [NEURONS];
    logic signed [31:0] ow_reg [NEURONS];
    logic signed [31:0] hd_reg [NEURONS];
    logic signed [31:0] od_reg [NEURONS];
    logic [16:0]        act_reg [NEURONS];

    logic               is_train_reg;
    logic signed [31:0] sample_reg, target_reg;
    logic signed [31:0] x_reg, y_reg, err_reg, oe_reg, tmp1_reg, tmp2_reg;
    logic signed [63:0] acc_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [IDX_W-1:0]   i_reg;

    logic               done_reg;
    logic signed [31:0] pred_reg, error_reg, hwo_reg, owo_reg;

    logic signed [33:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [31:0] r;
    logic [16:0]        o_new;
    logic               last;
    logic               accept;
    logic               idx_ok;
    logic signed [31:0] dv, dw;

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign done          = done_reg;
    assign prediction    = pred_reg;
    assign error         = error_reg;
    assign hidden_weight = hwo_reg;
    assign output_weight = owo_reg;

    assign r      = rnd_sat(prod_reg);
    assign o_new  = sigm(r);
    assign last   = (i_reg == IDX_W'(NEURONS - 1));
    assign idx_ok = ({1'b0, neuron_index} < 7'(NEURONS));
    assign dv     = sat_q(PROD_W'(tmp1_reg) + PROD_W'(r));
    assign dw     = sat_q(PROD_W'(tmp2_reg) + PROD_W'(r));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        mul_a      = '0;
        mul_b      = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept) begin
                    if (func == FUNC_TRAIN || func == FUNC_INFER)
                        state_next = ST_NX0;
                    else if (func == FUNC_READ && idx_ok)
                        state_next = ST_RD;
                end
            end
            ST_NX0:
            begin
                mul_a = 34'(sample_reg) - 34'(in_min_reg) + 34'(Q_ONE);
                mul_b = 33'(in_recip_reg);
                state_next = ST_NX1;
            end
            ST_NX1: state_next = ST_F1;
            ST_F1:
            begin
                mul_a = 34'(hw_reg[i_reg]);
                mul_b = 33'(x_reg);
                state_next = ST_F2;
            end
            ST_F2:
            begin
                mul_a = 34'(ow_reg[i_reg]);
                mul_b = 33'(o_new);
                state_next = ST_F3;
            end
            ST_F3: state_next = last ? ST_FY : ST_F1;
            ST_FY: state_next = is_train_reg ? ST_TM : ST_IM;
            ST_IM:
            begin
                mul_a = 34'(y_reg);
                mul_b = 33'(tgt_span_reg);
                state_next = ST_IP;
            end
            ST_IP: state_next = ST_IDLE;
            ST_TM:
            begin
                mul_a = 34'(target_reg) - 34'(tgt_min_reg) + 34'(Q_ONE);
                mul_b = 33'(tgt_recip_reg);
                state_next = ST_TE;
            end
            ST_TE: state_next = ST_OM;
            ST_OM:
            begin
                mul_a = 34'(orate_reg);
                mul_b = 33'(err_reg);
                state_next = ST_OE;
            end
            ST_OE: state_next = ST_B1;
            ST_B1:
            begin
                mul_a = 34'(mom_reg);
                mul_b = 33'(od_reg[i_reg]);
                state_next = ST_B2;
            end
            ST_B2:
            begin
                mul_a = 34'(oe_reg);
                mul_b = 33'(act_reg[i_reg]);
                state_next = ST_B3;
            end
            ST_B3:
            begin
                mul_a = 34'(err_reg);
                mul_b = 33'(ow_reg[i_reg]);
                state_next = ST_B4;
            end
            ST_B4:
            begin
                mul_a = 34'(act_reg[i_reg]);
                mul_b = 33'(17'd65536 - act_reg[i_reg]);
                state_next = ST_B5;
            end
            ST_B5:
            begin
                mul_a = 34'(hrate_reg);
                mul_b = 33'(tmp2_reg);
                state_next = ST_B6;
            end
            ST_B6:
            begin
                mul_a = 34'(r);
                mul_b = 33'(tmp1_reg);
                state_next = ST_B7;
            end
            ST_B7:
            begin
                mul_a = 34'(r);
                mul_b = 33'(x_reg);
                state_next = ST_B8;
            end
            ST_B8:
            begin
                mul_a = 34'(mom_reg);
                mul_b = 33'(hd_reg[i_reg]);
                state_next = ST_B9;
            end
            ST_B9: state_next = last ? ST_IDLE : ST_B1;
            ST_RD: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_min_reg    <= '0;
            in_recip_reg  <= 17'd65536;
            tgt_min_reg   <= '0;
            tgt_span_reg  <= 31'd65536;
            tgt_recip_reg <= 17'd65536;
            mom_reg       <= 17'd13107;
            orate_reg     <= 17'd26214;
            hrate_reg     <= 17'd19661;
        end else if (cfg_valid) begin
            unique case (reg_idx_t'(cfg_index))
                REG_IN_MIN:    in_min_reg    <= cfg_data;
                REG_IN_RECIP:  in_recip_reg  <= cfg_data[16:0];
                REG_TGT_MIN:   tgt_min_reg   <= cfg_data;
                REG_TGT_SPAN:  tgt_span_reg  <= cfg_data[30:0];
                REG_TGT_RECIP: tgt_recip_reg <= cfg_data[16:0];
                REG_MOMENTUM:  mom_reg       <= cfg_data[16:0];
                REG_OUT_RATE:  orate_reg     <= cfg_data[16:0];
                REG_HID_RATE:  hrate_reg     <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            done_reg <= 1'b0;
            for (int k = 0; k < NEURONS; k++) begin
                hw_reg[k] <= '0;
                ow_reg[k] <= '0;
                hd_reg[k] <= '0;
                od_reg[k] <= '0;
            end
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept) begin
                        if (func == FUNC_LOAD_HW && idx_ok)
                            hw_reg[neuron_index[IDX_W-1:0]] <= weight_value;
                        if (func == FUNC_LOAD_OW && idx_ok)
                            ow_reg[neuron_index[IDX_W-1:0]] <= weight_value;
                        if (!(func == FUNC_TRAIN || func == FUNC_INFER
                              || (func == FUNC_READ && idx_ok)))
                            done_reg <= 1'b1;
                    end
                end
                ST_IP, ST_RD: done_reg <= 1'b1;
                ST_B3:
                begin
                    od_reg[i_reg] <= dv;
                    ow_reg[i_reg] <= sat_q(PROD_W'(ow_reg[i_reg]) - PROD_W'(dv));
                end
                ST_B9:
                begin
                    hd_reg[i_reg] <= dw;
                    hw_reg[i_reg] <= sat_q(PROD_W'(hw_reg[i_reg]) - PROD_W'(dw));
                    if (last)
                        done_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(mul_a * mul_b);
        case (state_reg)
            ST_IDLE:
            begin
                if (accept) begin
                    is_train_reg <= (func == FUNC_TRAIN);
                    sample_reg   <= sample;
                    target_reg   <= target;
                    i_reg        <= idx_ok ? neuron_index[IDX_W-1:0] : '0;
                    pred_reg     <= '0;
                    error_reg    <= '0;
                    hwo_reg      <= '0;
                    owo_reg      <= '0;
                end
            end
            ST_NX1:
            begin
                x_reg   <= r;
                i_reg   <= '0;
                acc_reg <= '0;
            end
            ST_F2: act_reg[i_reg] <= o_new;
            ST_F3:
            begin
                acc_reg <= acc_reg + 64'(prod_reg);
                i_reg   <= last ? '0 : i_reg + 1'b1;
            end
            ST_FY: y_reg <= rnd_sat(PROD_W'(acc_reg));
            ST_IP:
            begin
                pred_reg <= sat_q(PROD_W'(r) + PROD_W'(tgt_min_reg) - PROD_W'(Q_ONE));
            end
            ST_TE:
            begin
                pred_reg  <= y_reg;
                err_reg   <= sat_q(PROD_W'(y_reg) - PROD_W'(r));
                error_reg <= sat_q(PROD_W'(y_reg) - PROD_W'(r));
            end
            ST_OE: oe_reg <= r;
            ST_B2: tmp1_reg <= r;
            ST_B4: tmp2_reg <= r;
            ST_B5: tmp1_reg <= r;
            ST_B8: tmp2_reg <= r;
            ST_B9: i_reg <= last ? '0 : i_reg + 1'b1;
            ST_RD:
            begin
                hwo_reg <= hw_reg[i_reg];
                owo_reg <= ow_reg[i_reg];
            end
            default: ;
        endcase
    end

endmodule
